/* sv/pkrt_pkg.sv */
package pkrt_pkg;

	localparam int NUM_KEYS_DEF   = 256;
	localparam int RING_DEPTH_DEF = 32;

	localparam int TS_W       = 32;
	localparam int WIN_W      = 16;
	localparam int OP_W       = 3;
	localparam int KEY_CODE_W = 8;
	localparam int RECENT_W   = 6;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

	localparam logic [OP_W-1:0] OP_KEY_EVENT    = 3'd0;
	localparam logic [OP_W-1:0] OP_QUERY        = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_TOTAL    = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR_TOTALS = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR_ALL    = 3'd4;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_KEY_RD,
		ST_KEY_WAIT,
		ST_PRUNE_RD,
		ST_PRUNE_CMP,
		ST_APPLY
	} pkrt_state_t;

	// key table port control
	typedef struct packed {
		logic rd_en;
		logic we_state;
		logic we_ring;
		logic clear;
	} kt_ctl_t;

endpackage

/* sv/pkrt_alu.sv */
module pkrt_alu (
	input  logic [pkrt_pkg::TS_W-1:0]  a,
	input  logic [pkrt_pkg::TS_W-1:0]  b,
	input  logic [pkrt_pkg::WIN_W-1:0] window,
	output logic [pkrt_pkg::TS_W-1:0]  diff,
	output logic                       stale
);

	// modulo 2^32 age and window compare
	assign diff  = a - b;
	assign stale = diff > {{(pkrt_pkg::TS_W-pkrt_pkg::WIN_W){1'b0}}, window};

endmodule

/* sv/pkrt_key_table.sv */
module pkrt_key_table #(
	parameter int NUM_KEYS   = pkrt_pkg::NUM_KEYS_DEF,
	parameter int RING_DEPTH = pkrt_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  pkrt_pkg::kt_ctl_t                   ctl,
	input  logic [$clog2(NUM_KEYS)-1:0]         addr,
	input  logic                                wr_down,
	input  logic [pkrt_pkg::TS_W-1:0]           wr_start,
	input  logic [pkrt_pkg::TS_W-1:0]           wr_total,
	input  logic [$clog2(RING_DEPTH)-1:0]       wr_head,
	input  logic [$clog2(RING_DEPTH+1)-1:0]     wr_cnt,
	output logic                                rd_down,
	output logic [pkrt_pkg::TS_W-1:0]           rd_start,
	output logic [pkrt_pkg::TS_W-1:0]           rd_total,
	output logic [$clog2(RING_DEPTH)-1:0]       rd_head,
	output logic [$clog2(RING_DEPTH+1)-1:0]     rd_cnt
);

	localparam int HW    = $clog2(RING_DEPTH);
	localparam int CW    = $clog2(RING_DEPTH+1);
	localparam int ST_W  = 1 + pkrt_pkg::TS_W;
	localparam int RNG_W = pkrt_pkg::TS_W + HW + CW;

	// down flag and press start, kept by clear totals
	logic [ST_W-1:0]  state_mem [NUM_KEYS];
	// total and ring pointers
	logic [RNG_W-1:0] ring_mem  [NUM_KEYS];

	logic [ST_W-1:0]  state_wdata;
	logic [RNG_W-1:0] ring_wdata;
	logic [ST_W-1:0]  state_rdata_q;
	logic [RNG_W-1:0] ring_rdata_q;

	assign state_wdata = ctl.clear ? '0 : {wr_down, wr_start};
	assign ring_wdata  = ctl.clear ? '0 : {wr_total, wr_head, wr_cnt};

	always_ff @(posedge clk) begin
		if (ctl.we_state) begin
			state_mem[addr] <= state_wdata;
		end
		if (ctl.we_ring) begin
			ring_mem[addr] <= ring_wdata;
		end
		if (ctl.rd_en) begin
			state_rdata_q <= state_mem[addr];
			ring_rdata_q  <= ring_mem[addr];
		end
	end

	assign {rd_down, rd_start}         = state_rdata_q;
	assign {rd_total, rd_head, rd_cnt} = ring_rdata_q;

endmodule

/* sv/pkrt_stamp_ram.sv */
module pkrt_stamp_ram #(
	parameter int AW = 13
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [pkrt_pkg::TS_W-1:0]     wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [pkrt_pkg::TS_W-1:0]     rdata
);

	logic [pkrt_pkg::TS_W-1:0] mem [2**AW];
	logic [pkrt_pkg::TS_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/per_key_press_rate_tracker.sv */
// per-key press rate tracker: each key has a down flag, a saturating press total, a press
// start time and a ring of recent press timestamps; every item with a key code below NUM_KEYS
// first drops stale stamps of the addressed key (age now_ms - stamp, modulo 2^32,
// greater than window_ms), then runs the operation and returns one result word; a key item
// reads the key table, then alternates stamp memory reads and compares until the oldest
// stamp is not stale or the ring is empty (at most RING_DEPTH stamps dropped), as the shared
// subtract/compare unit checks one stamp per stamp memory read; clear totals and clear
// everything first sweep the key table, one key a cycle; after reset the same sweep runs
// with s_axis_tready low; the final step waits while the previous result word is stalled,
// and the next word is taken from the cycle the result appears; a key code at or beyond
// NUM_KEYS skips the table read and pruning and gives an all-zero result; window_ms is
// written via cfg_we/cfg_wdata; write it only while idle, the block does not enforce it
module per_key_press_rate_tracker #(
	parameter int NUM_KEYS   = pkrt_pkg::NUM_KEYS_DEF,
	parameter int RING_DEPTH = pkrt_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input word
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// key_code[7:0], pressed[8], now_ms[40:9], new_total[72:41], zero[79:73]
	input  logic [pkrt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// operation[2:0]
	input  logic [pkrt_pkg::OP_W-1:0]          s_axis_tuser,
	// result word
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// key_is_down[0], press_total[32:1], recent_presses[38:33], event_accepted[39],
	// hold_duration[71:40]
	output logic [pkrt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// window_ms register
	input  logic                               cfg_we,
	input  logic [pkrt_pkg::WIN_W-1:0]         cfg_wdata
);

	localparam int KW   = $clog2(NUM_KEYS);
	localparam int HW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(RING_DEPTH+1);
	localparam int TS_W = pkrt_pkg::TS_W;

	localparam logic [KW-1:0] LAST_KEY  = KW'(NUM_KEYS - 1);
	localparam logic [HW-1:0] LAST_SLOT = HW'(RING_DEPTH - 1);

	pkrt_pkg::pkrt_state_t state_q, state_d;

	// control registers
	logic [pkrt_pkg::WIN_W-1:0] win_q;
	logic [KW-1:0]              clr_idx_q;
	logic                       clr_all_q;
	logic                       m_valid_q;

	// item and working registers
	logic [pkrt_pkg::OP_W-1:0]  op_q;
	logic [KW-1:0]              key_q;
	logic                       in_range_q;
	logic                       pressed_q;
	logic [TS_W-1:0]            now_q;
	logic [TS_W-1:0]            newtot_q;
	logic                       down_q;
	logic [TS_W-1:0]            start_q;
	logic [TS_W-1:0]            total_q;
	logic [HW-1:0]              head_q;
	logic [CW-1:0]              cnt_q;
	logic [pkrt_pkg::OUT_DATA_W-1:0] m_data_q;

	// input word fields
	logic [pkrt_pkg::KEY_CODE_W-1:0] in_key;
	logic                            in_range;
	logic                            s_acc;
	logic                            out_free;
	logic                            sweep_last;

	// table interfaces
	pkrt_pkg::kt_ctl_t  kt_ctl;
	logic [KW-1:0]      kt_addr;
	logic               kt_down;
	logic [TS_W-1:0]    kt_start;
	logic [TS_W-1:0]    kt_total;
	logic [HW-1:0]      kt_head;
	logic [CW-1:0]      kt_cnt;
	logic               rd_down_w;
	logic [TS_W-1:0]    rd_start_w;
	logic [TS_W-1:0]    rd_total_w;
	logic [HW-1:0]      rd_head_w;
	logic [CW-1:0]      rd_cnt_w;
	logic               st_we;
	logic               st_re;
	logic [KW+HW-1:0]   st_waddr;
	logic [TS_W-1:0]    st_rdata;

	// shared subtract/compare unit
	logic [TS_W-1:0]    alu_b;
	logic [TS_W-1:0]    alu_diff;
	logic               alu_stale;

	// apply-step values
	logic               is_event;
	logic               ev_acc;
	logic               press_acc;
	logic               rel_acc;
	logic               ring_full;
	logic [HW-1:0]      head_inc;
	logic [HW:0]        slot_sum;
	logic [HW-1:0]      push_slot;
	logic               new_down;
	logic [TS_W-1:0]    new_start;
	logic [TS_W-1:0]    new_total;
	logic [HW-1:0]      new_head;
	logic [CW-1:0]      new_cnt;
	logic [pkrt_pkg::RECENT_W-1:0] recent;
	logic [TS_W-1:0]    hold;
	logic [pkrt_pkg::OUT_DATA_W-1:0] result;

	assign in_key     = s_axis_tdata[7:0];
	assign in_range   = 32'(in_key) < NUM_KEYS;
	assign s_acc      = s_axis_tvalid && s_axis_tready;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign sweep_last = clr_idx_q == LAST_KEY;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pkrt_pkg::ST_INIT: begin
				if (sweep_last) begin
					state_d = pkrt_pkg::ST_IDLE;
				end
			end
			pkrt_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (s_axis_tuser == pkrt_pkg::OP_CLEAR_TOTALS ||
					    s_axis_tuser == pkrt_pkg::OP_CLEAR_ALL) begin
						state_d = pkrt_pkg::ST_CLEAR;
					end else if (in_range) begin
						state_d = pkrt_pkg::ST_KEY_RD;
					end else begin
						state_d = pkrt_pkg::ST_APPLY;
					end
				end
			end
			pkrt_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_d = in_range_q ? pkrt_pkg::ST_KEY_RD : pkrt_pkg::ST_APPLY;
				end
			end
			pkrt_pkg::ST_KEY_RD:   state_d = pkrt_pkg::ST_KEY_WAIT;
			pkrt_pkg::ST_KEY_WAIT: state_d = pkrt_pkg::ST_PRUNE_RD;
			pkrt_pkg::ST_PRUNE_RD: begin
				state_d = (cnt_q == '0) ? pkrt_pkg::ST_APPLY : pkrt_pkg::ST_PRUNE_CMP;
			end
			pkrt_pkg::ST_PRUNE_CMP: begin
				state_d = alu_stale ? pkrt_pkg::ST_PRUNE_RD : pkrt_pkg::ST_APPLY;
			end
			pkrt_pkg::ST_APPLY: begin
				if (out_free) begin
					state_d = pkrt_pkg::ST_IDLE;
				end
			end
			default: state_d = pkrt_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		kt_ctl        = '0;
		st_re         = 1'b0;
		st_we         = 1'b0;
		case (state_q)
			pkrt_pkg::ST_INIT: begin
				kt_ctl.clear    = 1'b1;
				kt_ctl.we_state = 1'b1;
				kt_ctl.we_ring  = 1'b1;
			end
			pkrt_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			pkrt_pkg::ST_CLEAR: begin
				// clear totals keeps down flags and press starts
				kt_ctl.clear    = 1'b1;
				kt_ctl.we_state = clr_all_q;
				kt_ctl.we_ring  = 1'b1;
			end
			pkrt_pkg::ST_KEY_RD: begin
				kt_ctl.rd_en = 1'b1;
			end
			pkrt_pkg::ST_PRUNE_RD: begin
				st_re = cnt_q != '0;
			end
			pkrt_pkg::ST_APPLY: begin
				kt_ctl.we_state = in_range_q && out_free;
				kt_ctl.we_ring  = in_range_q && out_free;
				st_we           = in_range_q && out_free && press_acc;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign kt_addr = (state_q == pkrt_pkg::ST_INIT || state_q == pkrt_pkg::ST_CLEAR) ?
	                 clr_idx_q : key_q;

	// age of oldest stamp while pruning, hold time on release
	assign alu_b = (state_q == pkrt_pkg::ST_APPLY) ? start_q : st_rdata;

	pkrt_alu u_alu (
		.a      (now_q),
		.b      (alu_b),
		.window (win_q),
		.diff   (alu_diff),
		.stale  (alu_stale)
	);

	// ring pointer arithmetic, modulo RING_DEPTH
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign slot_sum  = (HW+1)'(head_q) + (HW+1)'(cnt_q);
	assign push_slot = (slot_sum >= (HW+1)'(RING_DEPTH)) ?
	                   HW'(slot_sum - (HW+1)'(RING_DEPTH)) : HW'(slot_sum);
	assign ring_full = 32'(cnt_q) >= RING_DEPTH;

	// operation
	assign is_event  = op_q == pkrt_pkg::OP_KEY_EVENT;
	assign ev_acc    = in_range_q && is_event && (pressed_q != down_q);
	assign press_acc = ev_acc && pressed_q;
	assign rel_acc   = ev_acc && !pressed_q;
	assign new_down  = ev_acc ? pressed_q : down_q;
	assign new_start = press_acc ? now_q : start_q;

	always_comb begin
		new_total = total_q;
		if (op_q == pkrt_pkg::OP_SET_TOTAL) begin
			new_total = newtot_q;
		end else if (press_acc && total_q != '1) begin
			new_total = total_q + 1'b1;
		end
	end

	always_comb begin
		new_head = head_q;
		new_cnt  = cnt_q;
		if (press_acc) begin
			if (ring_full) begin
				// overwrite the oldest stamp
				new_head = head_inc;
			end else begin
				new_cnt = cnt_q + 1'b1;
			end
		end
	end

	assign st_waddr = {key_q, ring_full ? head_q : push_slot};
	assign recent   = (32'(new_cnt) > 63) ? '1 : pkrt_pkg::RECENT_W'(new_cnt);
	assign hold     = rel_acc ? alu_diff : '0;
	assign result   = in_range_q ? {hold, ev_acc, recent, new_total, new_down} : '0;

	assign kt_down  = new_down;
	assign kt_start = new_start;
	assign kt_total = new_total;
	assign kt_head  = new_head;
	assign kt_cnt   = new_cnt;

	pkrt_key_table #(
		.NUM_KEYS   (NUM_KEYS),
		.RING_DEPTH (RING_DEPTH)
	) u_key_table (
		.clk      (clk),
		.ctl      (kt_ctl),
		.addr     (kt_addr),
		.wr_down  (kt_down),
		.wr_start (kt_start),
		.wr_total (kt_total),
		.wr_head  (kt_head),
		.wr_cnt   (kt_cnt),
		.rd_down  (rd_down_w),
		.rd_start (rd_start_w),
		.rd_total (rd_total_w),
		.rd_head  (rd_head_w),
		.rd_cnt   (rd_cnt_w)
	);

	// stamp ring, addressed by {key, slot}
	pkrt_stamp_ram #(
		.AW (KW + HW)
	) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (now_q),
		.re    (st_re),
		.raddr ({key_q, head_q}),
		.rdata (st_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pkrt_pkg::ST_INIT;
			win_q     <= pkrt_pkg::WINDOW_RESET;
			clr_idx_q <= '0;
			clr_all_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (state_q == pkrt_pkg::ST_INIT || state_q == pkrt_pkg::ST_CLEAR) begin
				clr_idx_q <= sweep_last ? '0 : clr_idx_q + 1'b1;
			end
			if (s_acc) begin
				clr_all_q <= s_axis_tuser == pkrt_pkg::OP_CLEAR_ALL;
			end
			if (state_q == pkrt_pkg::ST_APPLY && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item and working registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q       <= s_axis_tuser;
			key_q      <= KW'(in_key);
			in_range_q <= in_range;
			pressed_q  <= s_axis_tdata[8];
			now_q      <= s_axis_tdata[40:9];
			newtot_q   <= s_axis_tdata[72:41];
		end
		if (state_q == pkrt_pkg::ST_KEY_WAIT) begin
			down_q  <= rd_down_w;
			start_q <= rd_start_w;
			total_q <= rd_total_w;
			head_q  <= rd_head_w;
			cnt_q   <= rd_cnt_w;
		end else if (state_q == pkrt_pkg::ST_PRUNE_CMP && alu_stale) begin
			// pop the oldest stamp
			head_q <= head_inc;
			cnt_q  <= cnt_q - 1'b1;
		end
		if (state_q == pkrt_pkg::ST_APPLY && out_free) begin
			m_data_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* sv/pkrt_checker.sv */
module pkrt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pkrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic out_acc_bit;
	logic out_down;
	logic [31:0] out_total;
	logic [5:0]  out_recent;
	logic [31:0] out_hold;

	assign out_acc_bit = m_axis_tdata[39];
	assign out_down    = m_axis_tdata[0];
	assign out_total   = m_axis_tdata[32:1];
	assign out_recent  = m_axis_tdata[38:33];
	assign out_hold    = m_axis_tdata[71:40];

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again in the cycle after an accept");

	// hold time only on an accepted release
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_hold != 32'd0 |-> out_acc_bit && !out_down)
		else $error("hold duration without an accepted release");

	// an accepted press counts and stamps
	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_acc_bit && out_down |-> out_total != 32'd0 && out_recent != 6'd0)
		else $error("accepted press left total or recent count at zero");

endmodule

bind per_key_press_rate_tracker pkrt_checker u_pkrt_checker (.*);
